// ===== hw/rtl/cct_pkg.sv =====
// Shared types, codes and helpers for the character-class run tokenizer.
`default_nettype none

package cct_pkg;

   // Result field widths
   localparam int TOK_W   = 17;
   localparam int KIND_W  = 2;
   localparam int CLS_W   = 2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_TOKEN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

   // Run classes (space/control is internal only, never reported)
   localparam logic [2:0] CLS_DIGIT = 3'd0;
   localparam logic [2:0] CLS_ALPHA = 3'd1;
   localparam logic [2:0] CLS_PUNCT = 3'd2;
   localparam logic [2:0] CLS_OTHER = 3'd3;
   localparam logic [2:0] CLS_SPACE = 3'd4;

   // Most results one byte can cause: closed run, multibyte token, finish
   localparam int MAX_RES = 3;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TOK_W-1:0]  token_start;
      logic [TOK_W-1:0]  token_end;
      logic [CLS_W-1:0]  token_class;
   } result_type;

   // All results caused by one byte, in order
   typedef struct packed {
      result_type [MAX_RES-1:0] res;
      logic [1:0]               count;
   } entry_type;

   // Append one result to an entry
   function automatic entry_type add_result(entry_type e, logic [KIND_W-1:0] kind,
                                            logic [TOK_W-1:0] s, logic [TOK_W-1:0] en,
                                            logic [CLS_W-1:0] cls);
      entry_type r;
      r = e;
      r.res[e.count].kind        = kind;
      r.res[e.count].token_start = s;
      r.res[e.count].token_end   = en;
      r.res[e.count].token_class = cls;
      r.count = e.count + 2'd1;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/char_class_run_tokenizer.sv =====
// Top level of the character-class run tokenizer.
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_ready | text_byte[7:0], last_byte
//  rsp_    | out       | rsp_valid / rsp_ready | kind, token_start, token_end,
//          |           |                       | token_class, run_last
//
// One byte is taken per cycle while the result queue has room; its results
// (up to three) leave one per cycle via the output register while rsp_ready
// is high, so the output port sets the sustained rate. They pass the queue,
// entry and output registers. Reset is synchronous and returns to start of
// text. A stalled rsp_ fills the four-entry queue, then req_ready drops.
`default_nettype none

module char_class_run_tokenizer import cct_pkg::*; #(
   parameter int MAX_TEXT = 65536
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [7:0]        req_text_byte,
   input  wire logic              req_last_byte,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [KIND_W-1:0] rsp_kind,
   output      logic [TOK_W-1:0]  rsp_token_start,
   output      logic [TOK_W-1:0]  rsp_token_end,
   output      logic [CLS_W-1:0]  rsp_token_class,
   output      logic              rsp_run_last
);

   logic      q_full;
   logic      q_push;
   entry_type q_push_entry;
   logic      q_pop;
   logic      q_valid;
   entry_type q_head;

   cct_front #(.MAX_TEXT(MAX_TEXT)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_push_entry)
   );

   cct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   cct_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_token_start (rsp_token_start),
      .rsp_token_end   (rsp_token_end),
      .rsp_token_class (rsp_token_class),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/cct_front.sv =====
// Front end: accepts bytes, classifies them, tracks runs and builds result entries.
`default_nettype none

module cct_front import cct_pkg::*; #(
   parameter int MAX_TEXT = 65536
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_last_byte,
   input  wire logic       q_full,
   output      logic       q_push,
   output      entry_type  q_entry
);

   localparam int POS_W = $clog2(MAX_TEXT + 1);
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [2:0]       class_ff, class_in;
   logic             open_ff, open_in;
   logic [1:0]       skip_ff, skip_in;
   logic             err_ff, err_in;

   logic [2:0] byte_cls;
   logic [2:0] lead_n;
   logic       accept;
   entry_type  ent;

   // C-locale class of an ASCII byte
   always_comb begin
      case (req_text_byte) inside
         [8'h30:8'h39]:                byte_cls = CLS_DIGIT;
         [8'h00:8'h20], 8'h7F:         byte_cls = CLS_SPACE;
         [8'h41:8'h5A], [8'h61:8'h7A]: byte_cls = CLS_ALPHA;
         default:                      byte_cls = CLS_PUNCT;
      endcase
   end

   // Leading ones of a high byte, capped at 4
   always_comb begin
      if (req_text_byte[7:4] == 4'hF)       lead_n = 3'd4;
      else if (req_text_byte[7:5] == 3'h7)  lead_n = 3'd3;
      else if (req_text_byte[7:6] == 2'h3)  lead_n = 3'd2;
      else                                  lead_n = 3'd1;
   end

   // Run tracking and result building for the offered byte
   always_comb begin
      ent      = '0;
      pos_in   = pos_ff;
      start_in = start_ff;
      class_in = class_ff;
      open_in  = open_ff;
      skip_in  = skip_ff;
      err_in   = err_ff;

      if (!err_ff) begin
         if (pos_ff == MAX_POS) begin
            // overlong text: close open run at the limit
            if (open_ff && class_ff != CLS_SPACE) begin
               ent = add_result(ent, KIND_TOKEN, TOK_W'(start_ff), TOK_W'(pos_ff),
                                class_ff[CLS_W-1:0]);
            end
            open_in = 1'b0;
            err_in  = 1'b1;
         end else begin
            if (skip_ff != 2'd0) begin
               skip_in = skip_ff - 2'd1;
            end else if (!req_text_byte[7]) begin
               if (!(open_ff && class_ff == byte_cls)) begin
                  if (open_ff && class_ff != CLS_SPACE) begin
                     ent = add_result(ent, KIND_TOKEN, TOK_W'(start_ff), TOK_W'(pos_ff),
                                      class_ff[CLS_W-1:0]);
                  end
                  open_in  = 1'b1;
                  class_in = byte_cls;
                  start_in = pos_ff;
               end
            end else begin
               if (open_ff && class_ff != CLS_SPACE) begin
                  ent = add_result(ent, KIND_TOKEN, TOK_W'(start_ff), TOK_W'(pos_ff),
                                   class_ff[CLS_W-1:0]);
               end
               open_in = 1'b0;
               if (lead_n == 3'd1) begin
                  // stray continuation byte
                  err_in = 1'b1;
               end else begin
                  ent = add_result(ent, KIND_TOKEN, TOK_W'(pos_ff),
                                   TOK_W'(pos_ff) + TOK_W'(lead_n), CLS_OTHER[CLS_W-1:0]);
                  skip_in = 2'(lead_n - 3'd1);
               end
            end
            if (!err_in) pos_in = pos_ff + POS_W'(1);
         end
      end

      // end of text: close run, report finish, return to reset state
      if (req_last_byte) begin
         if (!err_in) begin
            if (open_in && class_in != CLS_SPACE) begin
               ent = add_result(ent, KIND_TOKEN, TOK_W'(start_in), TOK_W'(pos_in),
                                class_in[CLS_W-1:0]);
            end
            if (skip_in != 2'd0) err_in = 1'b1;
         end
         ent = add_result(ent, err_in ? KIND_ERR : KIND_OK, '0, '0, '0);
         pos_in   = '0;
         start_in = '0;
         class_in = '0;
         open_in  = 1'b0;
         skip_in  = '0;
         err_in   = 1'b0;
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && (ent.count != 2'd0);
   assign q_entry   = ent;

   // Tokenizer state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         class_ff <= '0;
         open_ff  <= 1'b0;
         skip_ff  <= '0;
         err_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         class_ff <= class_in;
         open_ff  <= open_in;
         skip_ff  <= skip_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cct_queue.sv =====
// Short queue of result entries between the front and back ends.
`default_nettype none

module cct_queue import cct_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output      logic      full,
   input  wire logic      pop,
   output      logic      head_valid,
   output      entry_type head_entry
);

   entry_type          slots [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full       = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots[rd_ptr_ff];

   // Occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + (QPTR_W+1)'(1);
      else if (!push && pop) count_in = count_ff - (QPTR_W+1)'(1);
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) slots[wr_ptr_ff] <= push_entry;
   end

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cct_back.sv =====
// Back end: unpacks queued entries, one result per unstalled cycle via the output register.
`default_nettype none

module cct_back import cct_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire entry_type         q_entry,
   output      logic              q_pop,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [KIND_W-1:0] rsp_kind,
   output      logic [TOK_W-1:0]  rsp_token_start,
   output      logic [TOK_W-1:0]  rsp_token_end,
   output      logic [CLS_W-1:0]  rsp_token_class,
   output      logic              rsp_run_last
);

   entry_type   cur_ff;
   logic        cur_valid_ff;
   logic [1:0]  idx_ff;
   logic        valid_ff;
   result_type  out_ff;
   logic        last_ff;

   logic slot_free;
   logic advance;
   logic is_last;

   assign slot_free = !valid_ff || rsp_ready;
   assign advance   = slot_free && cur_valid_ff;
   assign is_last   = (idx_ff == cur_ff.count - 2'd1);
   assign q_pop     = q_valid && (!cur_valid_ff || (advance && is_last));

   // Current entry and result index
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (q_pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (advance) begin
         if (is_last) cur_valid_ff <= 1'b0;
         else         idx_ff       <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_entry;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff  <= cur_ff.res[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_token_start = out_ff.token_start;
   assign rsp_token_end   = out_ff.token_end;
   assign rsp_token_class = out_ff.token_class;
   assign rsp_run_last    = last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cct_checker.sv =====
// Port-level checker for the tokenizer, bound to the top level.
`default_nettype none

module cct_checker import cct_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [TOK_W-1:0]  rsp_token_start,
   input wire logic [TOK_W-1:0]  rsp_token_end,
   input wire logic [CLS_W-1:0]  rsp_token_class,
   input wire logic              rsp_run_last
);

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_token_start) && $stable(rsp_token_end)
         && $stable(rsp_run_last))
      else $error("stalled result changed");

   // Finish results close the byte's batch
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_OK || rsp_kind == KIND_ERR) |-> rsp_run_last)
      else $error("finish result not last of its byte");

   // Finish results carry zero token fields, and kind is a known code
   a_finish_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_TOKEN |-> (rsp_kind == KIND_OK || rsp_kind == KIND_ERR)
         && rsp_token_start == '0 && rsp_token_end == '0 && rsp_token_class == '0)
      else $error("bad finish result");

endmodule

bind char_class_run_tokenizer cct_checker u_cct_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_token_start (rsp_token_start),
   .rsp_token_end   (rsp_token_end),
   .rsp_token_class (rsp_token_class),
   .rsp_run_last    (rsp_run_last)
);

`default_nettype wire
